/* design/sbq_pkg.sv */
// Shared types and constants for the stereo biquad filter.
`timescale 1ns / 1ps

package sbq_pkg;

   // Coefficient format: signed Q2.22
   localparam int COEF_WIDTH      = 24;
   localparam int NUM_COEFS       = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   // b0 comes out of reset at unity gain
   localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 24'sd4194304;

   // Register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } csr_index_type;

   // Coefficient set shared by both lanes
   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

   // Occupancy of the output buffer
   typedef struct packed {
      logic main_full;
      logic skid_full;
   } merge_status_type;

endpackage

/* design/sbq_req_if.sv */
// Input channel: one stereo sample pair per transfer.
`timescale 1ns / 1ps

interface sbq_req_if #(
   parameter int WIDTH = 24
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample_left;
   logic signed [WIDTH-1:0] sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

/* design/sbq_rsp_if.sv */
// Result channel: one filtered stereo pair per transfer.
`timescale 1ns / 1ps

interface sbq_rsp_if #(
   parameter int WIDTH = 24
);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] filtered_left;
   logic signed [WIDTH-1:0] filtered_right;

   modport source (output valid, output filtered_left, output filtered_right, input ready);
   modport sink   (input valid, input filtered_left, input filtered_right, output ready);
endinterface

/* design/sbq_lane.sv */
// One channel of the direct-form-I biquad with its own sample history.
`timescale 1ns / 1ps

module sbq_lane #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  sbq_pkg::coef_set_type          coefs,
   output logic signed [SAMPLE_WIDTH-1:0] result
);

   localparam int PROD_W = SAMPLE_WIDTH + sbq_pkg::COEF_WIDTH;
   localparam int ACC_W  = PROD_W + 3;

   // Saturation bounds, sign-extended to the accumulator width
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_MIN =
      {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] x1_ff, x1_in;
   logic signed [SAMPLE_WIDTH-1:0] x2_ff, x2_in;
   logic signed [SAMPLE_WIDTH-1:0] y1_ff, y1_in;
   logic signed [SAMPLE_WIDTH-1:0] y2_ff, y2_in;

   logic signed [PROD_W-1:0] prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  shifted;

   // Five products, all at full width
   always_comb begin
      prod_b0 = PROD_W'(sample) * PROD_W'(coefs.b0);
      prod_b1 = PROD_W'(x1_ff)  * PROD_W'(coefs.b1);
      prod_b2 = PROD_W'(x2_ff)  * PROD_W'(coefs.b2);
      prod_a1 = PROD_W'(y1_ff)  * PROD_W'(coefs.a1);
      prod_a2 = PROD_W'(y2_ff)  * PROD_W'(coefs.a2);
   end

   // Exact sum, floor shift, saturate
   always_comb begin
      acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
          - ACC_W'(prod_a1) - ACC_W'(prod_a2);
      shifted = acc >>> COEF_FRAC_BITS;
      if (shifted > SAT_MAX) begin
         result = SAMPLE_WIDTH'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         result = SAMPLE_WIDTH'(SAT_MIN);
      end else begin
         result = SAMPLE_WIDTH'(shifted);
      end
   end

   // History shifts once per accepted pair
   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (step) begin
         x1_in = sample;
         x2_in = x1_ff;
         y1_in = result;
         y2_in = y1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

/* design/sbq_merge.sv */
// Joins the two lane results into one pair and buffers it (output + skid).
`timescale 1ns / 1ps

module sbq_merge #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic signed [SAMPLE_WIDTH-1:0] left_result,
   input  logic signed [SAMPLE_WIDTH-1:0] right_result,
   sbq_rsp_if.source                      rsp_ch,
   output sbq_pkg::merge_status_type      status
);

   logic main_valid_ff, main_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] main_left_ff,  main_left_in;
   logic signed [SAMPLE_WIDTH-1:0] main_right_ff, main_right_in;
   logic signed [SAMPLE_WIDTH-1:0] skid_left_ff,  skid_left_in;
   logic signed [SAMPLE_WIDTH-1:0] skid_right_ff, skid_right_in;
   logic take;

   assign take = main_valid_ff && rsp_ch.ready;

   // Buffer control: skid drains into main; new pairs go to main when free, else to skid
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_left_in  = main_left_ff;
      main_right_in = main_right_ff;
      skid_left_in  = skid_left_ff;
      skid_right_in = skid_right_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_left_in  = skid_left_ff;
            main_right_in = skid_right_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || take) begin
            main_left_in  = left_result;
            main_right_in = right_result;
            main_valid_in = 1'b1;
         end else begin
            skid_left_in  = left_result;
            skid_right_in = right_result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_left_ff  <= main_left_in;
      main_right_ff <= main_right_in;
      skid_left_ff  <= skid_left_in;
      skid_right_ff <= skid_right_in;
   end

   assign rsp_ch.valid          = main_valid_ff;
   assign rsp_ch.filtered_left  = main_left_ff;
   assign rsp_ch.filtered_right = main_right_ff;
   assign status.main_full      = main_valid_ff;
   assign status.skid_full      = skid_valid_ff;

endmodule

/* design/stereo_biquad_filter.sv */
// Top level of the stereo biquad filter: coefficient registers, two lanes, output buffer.
`timescale 1ns / 1ps

// Stereo direct-form-I biquad, one left/right sample pair per transfer.
// req_ch carries sample_left/sample_right; rsp_ch returns filtered_left/right,
// one pair for each accepted pair, in order. Both channels share the five
// Q2.22 coefficients written through csr_wr_en/csr_index/csr_wdata
// (0 b0, 1 b1, 2 b2, 3 a1, 4 a2; other indexes are ignored). Write them
// only while no pair is in flight.
// Each result is registered in the output register (or the skid while that
// is held) before rsp_ch shows it. Throughput: one pair per cycle while
// req_ch.ready is high. Each lane forms its five products, sums, shifts and
// saturates in the accept cycle, as y1 feeds the next pair; this sets the rate.
// Stall: a two-entry output buffer (output register plus skid) lets one more
// pair in while a result waits; req_ch.ready drops only when both are full.
// Reset (synchronous): histories clear to zero, b0 returns to 1.0 and the
// others to zero, and the output buffer empties.
module stereo_biquad_filter #(
   parameter int SAMPLE_WIDTH   = 24,
   parameter int COEF_FRAC_BITS = 22
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sbq_req_if.sink                                req_ch,
   sbq_rsp_if.source                              rsp_ch,
   input  logic                                   csr_wr_en,
   input  logic [sbq_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic signed [sbq_pkg::COEF_WIDTH-1:0]  csr_wdata
);

   sbq_pkg::coef_set_type     coef_ff, coef_in;
   sbq_pkg::merge_status_type merge_status;
   logic                      accept;
   logic signed [SAMPLE_WIDTH-1:0] left_result;
   logic signed [SAMPLE_WIDTH-1:0] right_result;

   // Coefficient register writes
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sbq_pkg::CSR_B0: coef_in.b0 = csr_wdata;
            sbq_pkg::CSR_B1: coef_in.b1 = csr_wdata;
            sbq_pkg::CSR_B2: coef_in.b2 = csr_wdata;
            sbq_pkg::CSR_A1: coef_in.a1 = csr_wdata;
            sbq_pkg::CSR_A2: coef_in.a2 = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= sbq_pkg::B0_RESET;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Input handshake
   assign req_ch.ready = !merge_status.skid_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Lanes
   sbq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .sample (req_ch.sample_left),
      .coefs  (coef_ff),
      .result (left_result)
   );

   sbq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .sample (req_ch.sample_right),
      .coefs  (coef_ff),
      .result (right_result)
   );

   // Merge and output buffer
   sbq_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .push         (accept),
      .left_result  (left_result),
      .right_result (right_result),
      .rsp_ch       (rsp_ch),
      .status       (merge_status)
   );

`ifndef SYNTHESIS
   // Skid entry is only ever used behind a full output register
   assert property (@(posedge clock) disable iff (reset)
      merge_status.skid_full |-> merge_status.main_full)
      else $error("skid full while output register empty");

   // A pair accepted into an empty buffer shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept && !merge_status.main_full |=> rsp_ch.valid)
      else $error("accepted pair did not reach the output");

   // A b0 write lands in the coefficient register
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && csr_index == sbq_pkg::CSR_B0 |=> coef_ff.b0 == $past(csr_wdata))
      else $error("b0 write lost");
`endif

endmodule
